/* design/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants for the SOCKS5 handshake parser: protocol bytes,
// result codes, parser phases and the job word passed from front to back.
// ----------------------------------------------------------------------------
package shp_pkg;

   // protocol bytes
   localparam logic [7:0] K_VER     = 8'h05;
   localparam logic [7:0] K_NOAUTH  = 8'h00;
   localparam logic [7:0] K_REJECT  = 8'hFF;
   localparam logic [7:0] K_CONNECT = 8'h01;
   localparam logic [7:0] K_AT_V4   = 8'h01;
   localparam logic [7:0] K_AT_DOM  = 8'h03;
   localparam logic [7:0] K_AT_V6   = 8'h04;
   localparam logic [7:0] K_NOTSUP  = 8'h07;
   localparam logic [7:0] K_SUCCESS = 8'h00;
   localparam logic [7:0] ASCII_A   = 8'h41;
   localparam logic [7:0] ASCII_Z   = 8'h5A;

   // result kinds
   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_ADDR   = 2'd1;
   localparam logic [1:0] KIND_PORT   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // address kinds
   localparam logic [1:0] AK_IPV4   = 2'd0;
   localparam logic [1:0] AK_DOMAIN = 2'd1;
   localparam logic [1:0] AK_IPV6   = 2'd2;

   // session status codes
   localparam logic [3:0] ST_CONT       = 4'd0;
   localparam logic [3:0] ST_SUCCESS    = 4'd1;
   localparam logic [3:0] ST_HTTP       = 4'd2;
   localparam logic [3:0] ST_UNKNOWN    = 4'd3;
   localparam logic [3:0] ST_NO_METHODS = 4'd4;
   localparam logic [3:0] ST_NO_AUTH    = 4'd5;
   localparam logic [3:0] ST_BAD_VER    = 4'd6;
   localparam logic [3:0] ST_BAD_CMD    = 4'd7;
   localparam logic [3:0] ST_BAD_ATYP   = 4'd8;

   // pending request failure, kept in methods_left during the request header
   localparam logic [7:0] PEND_NONE = 8'd0;
   localparam logic [7:0] PEND_VER  = 8'd6;
   localparam logic [7:0] PEND_CMD  = 8'd7;

   localparam logic [7:0] IPV4_LEN = 8'd4;
   localparam logic [7:0] IPV6_LEN = 8'd16;

   // 10-byte reply layout
   localparam logic [3:0] RPL_VER_IDX  = 4'd0;
   localparam logic [3:0] RPL_CODE_IDX = 4'd1;
   localparam logic [3:0] RPL_ATYP_IDX = 4'd3;
   localparam logic [3:0] RPL_LAST_IDX = 4'd9;

   typedef enum logic [11:0] {
      PH_IDLE  = 12'b0000_0000_0001,
      PH_NMETH = 12'b0000_0000_0010,
      PH_METH  = 12'b0000_0000_0100,
      PH_RVER  = 12'b0000_0000_1000,
      PH_RCMD  = 12'b0000_0001_0000,
      PH_RRSV  = 12'b0000_0010_0000,
      PH_RATYP = 12'b0000_0100_0000,
      PH_DLEN  = 12'b0000_1000_0000,
      PH_ADDR  = 12'b0001_0000_0000,
      PH_PHI   = 12'b0010_0000_0000,
      PH_PLO   = 12'b0100_0000_0000,
      PH_DONE  = 12'b1000_0000_0000
   } phase_type;

   typedef enum logic [2:0] {
      OP_STATUS = 3'd0,  // single status-only item
      OP_AUTH   = 3'd1,  // 05 then method byte
      OP_ADDR   = 3'd2,  // one address byte
      OP_PORT   = 3'd3,  // port item then 10-byte reply
      OP_REPLY  = 3'd4   // 10-byte reply alone
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;       // address byte, method byte or reply code
      logic [15:0] port;
      logic [1:0]  addr_type;
      logic [3:0]  status;     // status carried by the job's final item
   } cmd_type;

endpackage

/* design/shp_if.sv */
// ----------------------------------------------------------------------------
// shp_if
// Valid/ready channels for client bytes in and handshake results out.
// ----------------------------------------------------------------------------
interface shp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       new_session;

   modport source (output valid, output rx_byte, output new_session, input ready);
   modport sink   (input valid, input rx_byte, input new_session, output ready);
endinterface

interface shp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic [1:0]  addr_type;
   logic [15:0] target_port;
   logic [3:0]  status;
   logic        last;

   modport source (output valid, output out_kind, output out_byte, output addr_type,
                   output target_port, output status, output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input addr_type,
                   input target_port, input status, input last, output ready);
endinterface

/* design/socks5_handshake_parser.sv */
// ----------------------------------------------------------------------------
// socks5_handshake_parser
// Server side of a SOCKS5 greeting and CONNECT request, one client byte per
// item, with reply, address, port and status items on the result channel.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                              
//   req_ch   in   rx_byte, new_session                                 
//   rsp_ch   out  out_kind, out_byte, addr_type, target_port, status, last
//
// One client byte is taken per cycle while the job queue has room; results
// leave at one item per cycle while rsp_ch is ready, so a byte that opens
// an 11-item reply holds the result side while the parser runs on into the
// queue. Each result passes through a queue slot and then the output reg.
// Synchronous reset returns the parser to its first-byte phase and empties
// the queue and output stage. Either side may stall without losing items.
// ----------------------------------------------------------------------------
module socks5_handshake_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   shp_req_if.sink   req_ch,
   shp_rsp_if.source rsp_ch
);

   shp_pkg::cmd_type push_cmd, head_cmd;
   logic             push, pop, q_empty, q_full;

   shp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (push),
      .q_cmd  (push_cmd)
   );

   shp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   shp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head_cmd),
      .q_empty (q_empty),
      .q_pop   (pop),
      .rsp     (rsp_ch)
   );

endmodule

/* design/shp_front.sv */
// ----------------------------------------------------------------------------
// shp_front
// Handshake state machine: takes one client byte per cycle while the queue has
// room, tracks the phase and posts a job for every byte that produces results.
// ----------------------------------------------------------------------------
module shp_front (
   input  logic             clock,
   input  logic             reset,
   shp_req_if.sink          req,
   input  logic             q_full,
   output logic             q_push,
   output shp_pkg::cmd_type q_cmd
);

   shp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [7:0] methods_left_ff, methods_left_in, cur_methods_left, meth_dec;
   logic       no_auth_ff, no_auth_in, cur_no_auth;
   logic [1:0] addr_kind_ff, addr_kind_in, cur_addr_kind;
   logic [7:0] addr_left_ff, addr_left_in, cur_addr_left, addr_dec;
   logic [7:0] port_high_ff, port_high_in, cur_port_high;
   logic       accept;
   logic [7:0] b;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   // new_session restarts the parser before this byte is looked at
   always_comb begin
      if (req.new_session) begin
         cur_phase        = shp_pkg::PH_IDLE;
         cur_methods_left = '0;
         cur_no_auth      = 1'b0;
         cur_addr_kind    = '0;
         cur_addr_left    = '0;
         cur_port_high    = '0;
      end else begin
         cur_phase        = phase_ff;
         cur_methods_left = methods_left_ff;
         cur_no_auth      = no_auth_ff;
         cur_addr_kind    = addr_kind_ff;
         cur_addr_left    = addr_left_ff;
         cur_port_high    = port_high_ff;
      end
   end

   assign meth_dec = cur_methods_left - 8'd1;
   assign addr_dec = cur_addr_left - 8'd1;

   always_comb begin
      phase_in        = cur_phase;
      methods_left_in = cur_methods_left;
      no_auth_in      = cur_no_auth;
      addr_kind_in    = cur_addr_kind;
      addr_left_in    = cur_addr_left;
      port_high_in    = cur_port_high;
      q_push          = 1'b0;
      q_cmd.op        = shp_pkg::OP_STATUS;
      q_cmd.data      = '0;
      q_cmd.port      = '0;
      q_cmd.status    = shp_pkg::ST_CONT;

      case (cur_phase)
         shp_pkg::PH_IDLE: begin
            if (b == shp_pkg::K_VER) begin
               phase_in = shp_pkg::PH_NMETH;
            end else begin
               phase_in     = shp_pkg::PH_DONE;
               q_push       = 1'b1;
               q_cmd.status = (b >= shp_pkg::ASCII_A && b <= shp_pkg::ASCII_Z) ?
                              shp_pkg::ST_HTTP : shp_pkg::ST_UNKNOWN;
            end
         end
         shp_pkg::PH_NMETH: begin
            if (b == 8'd0) begin
               phase_in     = shp_pkg::PH_DONE;
               q_push       = 1'b1;
               q_cmd.status = shp_pkg::ST_NO_METHODS;
            end else begin
               methods_left_in = b;
               no_auth_in      = 1'b0;
               phase_in        = shp_pkg::PH_METH;
            end
         end
         shp_pkg::PH_METH: begin
            no_auth_in      = cur_no_auth || (b == shp_pkg::K_NOAUTH);
            methods_left_in = meth_dec;
            if (meth_dec == 8'd0) begin
               q_push   = 1'b1;
               q_cmd.op = shp_pkg::OP_AUTH;
               if (no_auth_in) begin
                  q_cmd.data = shp_pkg::K_NOAUTH;
                  phase_in   = shp_pkg::PH_RVER;
               end else begin
                  q_cmd.data   = shp_pkg::K_REJECT;
                  q_cmd.status = shp_pkg::ST_NO_AUTH;
                  phase_in     = shp_pkg::PH_DONE;
               end
            end
         end
         shp_pkg::PH_RVER: begin
            methods_left_in = (b == shp_pkg::K_VER) ? shp_pkg::PEND_NONE : shp_pkg::PEND_VER;
            phase_in        = shp_pkg::PH_RCMD;
         end
         shp_pkg::PH_RCMD: begin
            if (cur_methods_left == shp_pkg::PEND_NONE && b != shp_pkg::K_CONNECT) begin
               methods_left_in = shp_pkg::PEND_CMD;
            end
            phase_in = shp_pkg::PH_RRSV;
         end
         shp_pkg::PH_RRSV: begin
            phase_in = shp_pkg::PH_RATYP;
         end
         shp_pkg::PH_RATYP: begin
            methods_left_in = shp_pkg::PEND_NONE;
            if (cur_methods_left == shp_pkg::PEND_VER) begin
               phase_in     = shp_pkg::PH_DONE;
               q_push       = 1'b1;
               q_cmd.status = shp_pkg::ST_BAD_VER;
            end else if (cur_methods_left == shp_pkg::PEND_CMD) begin
               phase_in     = shp_pkg::PH_DONE;
               q_push       = 1'b1;
               q_cmd.op     = shp_pkg::OP_REPLY;
               q_cmd.data   = shp_pkg::K_NOTSUP;
               q_cmd.status = shp_pkg::ST_BAD_CMD;
            end else if (b == shp_pkg::K_AT_V4) begin
               addr_kind_in = shp_pkg::AK_IPV4;
               addr_left_in = shp_pkg::IPV4_LEN;
               phase_in     = shp_pkg::PH_ADDR;
            end else if (b == shp_pkg::K_AT_DOM) begin
               addr_kind_in = shp_pkg::AK_DOMAIN;
               phase_in     = shp_pkg::PH_DLEN;
            end else if (b == shp_pkg::K_AT_V6) begin
               addr_kind_in = shp_pkg::AK_IPV6;
               addr_left_in = shp_pkg::IPV6_LEN;
               phase_in     = shp_pkg::PH_ADDR;
            end else begin
               phase_in     = shp_pkg::PH_DONE;
               q_push       = 1'b1;
               q_cmd.status = shp_pkg::ST_BAD_ATYP;
            end
         end
         shp_pkg::PH_DLEN: begin
            addr_left_in = b;
            phase_in     = (b == 8'd0) ? shp_pkg::PH_PHI : shp_pkg::PH_ADDR;
         end
         shp_pkg::PH_ADDR: begin
            q_push       = 1'b1;
            q_cmd.op     = shp_pkg::OP_ADDR;
            q_cmd.data   = b;
            addr_left_in = addr_dec;
            if (addr_dec == 8'd0) begin
               phase_in = shp_pkg::PH_PHI;
            end
         end
         shp_pkg::PH_PHI: begin
            port_high_in = b;
            phase_in     = shp_pkg::PH_PLO;
         end
         shp_pkg::PH_PLO: begin
            q_push       = 1'b1;
            q_cmd.op     = shp_pkg::OP_PORT;
            q_cmd.data   = shp_pkg::K_SUCCESS;
            q_cmd.port   = {cur_port_high, b};
            q_cmd.status = shp_pkg::ST_SUCCESS;
            phase_in     = shp_pkg::PH_DONE;
         end
         default: begin
            phase_in = shp_pkg::PH_DONE;
         end
      endcase

      q_cmd.addr_type = addr_kind_in;
      q_push          = q_push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= shp_pkg::PH_IDLE;
         methods_left_ff <= '0;
         no_auth_ff      <= 1'b0;
         addr_kind_ff    <= '0;
         addr_left_ff    <= '0;
         port_high_ff    <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         methods_left_ff <= methods_left_in;
         no_auth_ff      <= no_auth_in;
         addr_kind_ff    <= addr_kind_in;
         addr_left_ff    <= addr_left_in;
         port_high_ff    <= port_high_in;
      end
   end

   // a byte that ends the session with a bare status leaves the parser finished
   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.op == shp_pkg::OP_STATUS |=> phase_ff == shp_pkg::PH_DONE)
      else $error("status job posted without finishing the session");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job posted into a full queue");

endmodule

/* design/shp_queue.sv */
// ----------------------------------------------------------------------------
// shp_queue
// Small job FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module shp_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  shp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output shp_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   shp_pkg::cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty job queue");

endmodule

/* design/shp_back.sv */
// ----------------------------------------------------------------------------
// shp_back
// Result sequencer: expands the job at the queue head into result items, one
// per cycle while rsp is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module shp_back (
   input  logic             clock,
   input  logic             reset,
   input  shp_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   shp_rsp_if.source        rsp
);

   logic [3:0]  idx_ff, idx_in, rpl_idx;
   logic        load;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_c;
   logic [7:0]  byte_ff, byte_c, rpl_byte;
   logic [1:0]  atype_ff;
   logic [15:0] port_ff, port_c;
   logic [3:0]  status_ff, status_c;
   logic        last_ff, last_c;

   // the port job carries its port item ahead of the 10-byte reply
   assign rpl_idx = (head.op == shp_pkg::OP_PORT) ? idx_ff - 4'd1 : idx_ff;

   always_comb begin
      case (rpl_idx)
         shp_pkg::RPL_VER_IDX:  rpl_byte = shp_pkg::K_VER;
         shp_pkg::RPL_CODE_IDX: rpl_byte = head.data;
         shp_pkg::RPL_ATYP_IDX: rpl_byte = shp_pkg::K_AT_V4;
         default:               rpl_byte = 8'h00;
      endcase
   end

   always_comb begin
      kind_c   = shp_pkg::KIND_REPLY;
      byte_c   = '0;
      port_c   = '0;
      status_c = shp_pkg::ST_CONT;
      last_c   = 1'b1;
      case (head.op)
         shp_pkg::OP_STATUS: begin
            kind_c   = shp_pkg::KIND_STATUS;
            status_c = head.status;
         end
         shp_pkg::OP_AUTH: begin
            last_c = (idx_ff != 4'd0);
            if (idx_ff == 4'd0) begin
               byte_c = shp_pkg::K_VER;
            end else begin
               byte_c   = head.data;
               status_c = head.status;
            end
         end
         shp_pkg::OP_ADDR: begin
            kind_c = shp_pkg::KIND_ADDR;
            byte_c = head.data;
         end
         shp_pkg::OP_PORT, shp_pkg::OP_REPLY: begin
            if (head.op == shp_pkg::OP_PORT && idx_ff == 4'd0) begin
               kind_c = shp_pkg::KIND_PORT;
               port_c = head.port;
               last_c = 1'b0;
            end else begin
               byte_c   = rpl_byte;
               last_c   = (rpl_idx == shp_pkg::RPL_LAST_IDX);
               status_c = last_c ? head.status : shp_pkg::ST_CONT;
            end
         end
         default: begin
            kind_c = shp_pkg::KIND_STATUS;
         end
      endcase
   end

   assign load         = !q_empty && (!rsp_valid_ff || rsp.ready);
   assign q_pop        = load && last_c;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   assign idx_in       = last_c ? 4'd0 : idx_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_c;
         byte_ff   <= byte_c;
         atype_ff  <= head.addr_type;
         port_ff   <= port_c;
         status_ff <= status_c;
         last_ff   <= last_c;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_kind    = kind_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.addr_type   = atype_ff;
   assign rsp.target_port = port_ff;
   assign rsp.status      = status_ff;
   assign rsp.last        = last_ff;

   // a job leaves the queue only with its final item
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff && last_ff)
      else $error("job retired without its final item");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      load && !last_c |=> idx_ff != 4'd0 && idx_ff <= shp_pkg::RPL_LAST_IDX + 4'd1)
      else $error("item counter out of step with the job");

endmodule

/* tb/shp_result_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shp_result_check
// Watches both channels of the SOCKS5 handshake parser. Every accepted client
// byte runs through a cycle-free model of the parser. The results it predicts
// are queued and compared, field by field and in order, with the result items
// the block hands out.
// ----------------------------------------------------------------------------
module shp_result_check (
   input  logic clock,
   input  logic reset,
   shp_req_if   req_mon,
   shp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   connect_count
);

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [1:0]  atyp;
      logic [15:0] port;
      logic [3:0]  status;
      logic        last;
   } result_type;

   result_type expected_q[$];

   // parser state
   shp_pkg::phase_type parse_phase;
   logic [7:0]         meth_left;
   logic               auth_ok;
   logic [7:0]         req_fault;
   logic [1:0]         atyp_kind;
   logic [7:0]         addr_left;
   logic [7:0]         port_hi;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      connect_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_session();
      parse_phase = shp_pkg::PH_IDLE;
      meth_left   = 8'd0;
      auth_ok     = 1'b0;
      req_fault   = shp_pkg::PEND_NONE;
      atyp_kind   = shp_pkg::AK_IPV4;
      addr_left   = 8'd0;
      port_hi     = 8'd0;
   endtask

   task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                                input logic [15:0] port, input logic [3:0] status,
                                input logic last);
      result_type r;
      r.kind   = kind;
      r.data   = data;
      r.atyp   = atyp_kind;
      r.port   = port;
      r.status = status;
      r.last   = last;
      expected_q.insert(expected_q.size(), r);
   endtask

   // 05 code 00 01 00 00 00 00 00 00, status on the final byte
   task automatic expect_reply10(input logic [7:0] code, input logic [3:0] final_status);
      logic [7:0] b;
      for (int i = 0; i < 10; i++) begin
         if (i == shp_pkg::RPL_VER_IDX) b = shp_pkg::K_VER;
         else if (i == shp_pkg::RPL_CODE_IDX) b = code;
         else if (i == shp_pkg::RPL_ATYP_IDX) b = shp_pkg::K_AT_V4;
         else b = 8'h00;
         if (i == shp_pkg::RPL_LAST_IDX)
            expect_result(shp_pkg::KIND_REPLY, b, 16'h0, final_status, 1'b1);
         else
            expect_result(shp_pkg::KIND_REPLY, b, 16'h0, shp_pkg::ST_CONT, 1'b0);
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic fresh);
      if (fresh) clear_session();
      case (parse_phase)
         shp_pkg::PH_IDLE: begin
            if (b == shp_pkg::K_VER) begin
               parse_phase = shp_pkg::PH_NMETH;
            end else begin
               parse_phase = shp_pkg::PH_DONE;
               expect_result(shp_pkg::KIND_STATUS, 8'h00, 16'h0,
                             (b >= shp_pkg::ASCII_A && b <= shp_pkg::ASCII_Z) ?
                             shp_pkg::ST_HTTP : shp_pkg::ST_UNKNOWN, 1'b1);
            end
         end
         shp_pkg::PH_NMETH: begin
            if (b == 8'd0) begin
               parse_phase = shp_pkg::PH_DONE;
               expect_result(shp_pkg::KIND_STATUS, 8'h00, 16'h0,
                             shp_pkg::ST_NO_METHODS, 1'b1);
            end else begin
               meth_left   = b;
               auth_ok     = 1'b0;
               parse_phase = shp_pkg::PH_METH;
            end
         end
         shp_pkg::PH_METH: begin
            if (b == shp_pkg::K_NOAUTH) auth_ok = 1'b1;
            meth_left = meth_left - 8'd1;
            if (meth_left == 8'd0) begin
               expect_result(shp_pkg::KIND_REPLY, shp_pkg::K_VER, 16'h0,
                             shp_pkg::ST_CONT, 1'b0);
               if (auth_ok) begin
                  expect_result(shp_pkg::KIND_REPLY, shp_pkg::K_NOAUTH, 16'h0,
                                shp_pkg::ST_CONT, 1'b1);
                  parse_phase = shp_pkg::PH_RVER;
               end else begin
                  expect_result(shp_pkg::KIND_REPLY, shp_pkg::K_REJECT, 16'h0,
                                shp_pkg::ST_NO_AUTH, 1'b1);
                  parse_phase = shp_pkg::PH_DONE;
               end
            end
         end
         shp_pkg::PH_RVER: begin
            req_fault   = (b == shp_pkg::K_VER) ? shp_pkg::PEND_NONE : shp_pkg::PEND_VER;
            parse_phase = shp_pkg::PH_RCMD;
         end
         shp_pkg::PH_RCMD: begin
            // a bad version already pending takes precedence
            if (req_fault == shp_pkg::PEND_NONE && b != shp_pkg::K_CONNECT)
               req_fault = shp_pkg::PEND_CMD;
            parse_phase = shp_pkg::PH_RRSV;
         end
         shp_pkg::PH_RRSV: begin
            parse_phase = shp_pkg::PH_RATYP;
         end
         shp_pkg::PH_RATYP: begin
            if (req_fault == shp_pkg::PEND_VER) begin
               parse_phase = shp_pkg::PH_DONE;
               expect_result(shp_pkg::KIND_STATUS, 8'h00, 16'h0,
                             shp_pkg::ST_BAD_VER, 1'b1);
            end else if (req_fault == shp_pkg::PEND_CMD) begin
               parse_phase = shp_pkg::PH_DONE;
               expect_reply10(shp_pkg::K_NOTSUP, shp_pkg::ST_BAD_CMD);
            end else if (b == shp_pkg::K_AT_V4) begin
               atyp_kind   = shp_pkg::AK_IPV4;
               addr_left   = shp_pkg::IPV4_LEN;
               parse_phase = shp_pkg::PH_ADDR;
            end else if (b == shp_pkg::K_AT_DOM) begin
               atyp_kind   = shp_pkg::AK_DOMAIN;
               parse_phase = shp_pkg::PH_DLEN;
            end else if (b == shp_pkg::K_AT_V6) begin
               atyp_kind   = shp_pkg::AK_IPV6;
               addr_left   = shp_pkg::IPV6_LEN;
               parse_phase = shp_pkg::PH_ADDR;
            end else begin
               parse_phase = shp_pkg::PH_DONE;
               expect_result(shp_pkg::KIND_STATUS, 8'h00, 16'h0,
                             shp_pkg::ST_BAD_ATYP, 1'b1);
            end
            req_fault = shp_pkg::PEND_NONE;
         end
         shp_pkg::PH_DLEN: begin
            addr_left   = b;
            parse_phase = (b == 8'd0) ? shp_pkg::PH_PHI : shp_pkg::PH_ADDR;
         end
         shp_pkg::PH_ADDR: begin
            expect_result(shp_pkg::KIND_ADDR, b, 16'h0, shp_pkg::ST_CONT, 1'b1);
            addr_left = addr_left - 8'd1;
            if (addr_left == 8'd0) parse_phase = shp_pkg::PH_PHI;
         end
         shp_pkg::PH_PHI: begin
            port_hi     = b;
            parse_phase = shp_pkg::PH_PLO;
         end
         shp_pkg::PH_PLO: begin
            expect_result(shp_pkg::KIND_PORT, 8'h00, {port_hi, b}, shp_pkg::ST_CONT, 1'b0);
            expect_reply10(shp_pkg::K_SUCCESS, shp_pkg::ST_SUCCESS);
            parse_phase = shp_pkg::PH_DONE;
            connect_count++;
         end
         default: begin
            parse_phase = shp_pkg::PH_DONE;
         end
      endcase
   endtask

   task automatic check_result();
      result_type e;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("unexpected item: kind %0d byte %02h status %0d last %0d",
                                   rsp_mon.out_kind, rsp_mon.out_byte, rsp_mon.status,
                                   rsp_mon.last));
      end else begin
         e = expected_q.pop_front();
         checked_count++;
         if (rsp_mon.out_kind !== e.kind || rsp_mon.out_byte !== e.data ||
             rsp_mon.addr_type !== e.atyp || rsp_mon.target_port !== e.port ||
             rsp_mon.status !== e.status || rsp_mon.last !== e.last)
            report_mismatch($sformatf({"item %0d got kind %0d byte %02h atyp %0d port %04h ",
                                       "st %0d last %0d, want %0d %02h %0d %04h %0d %0d"},
                                      checked_count, rsp_mon.out_kind, rsp_mon.out_byte,
                                      rsp_mon.addr_type, rsp_mon.target_port,
                                      rsp_mon.status, rsp_mon.last, e.kind, e.data,
                                      e.atyp, e.port, e.status, e.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         clear_session();
      end else begin
         if (req_mon.valid && req_mon.ready) predict_byte(req_mon.rx_byte, req_mon.new_session);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      pending_count = expected_q.size();
   end

endmodule

/* tb/socks5_handshake_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// socks5_handshake_parser_tb
// Feeds client byte streams into the parser: a few directed openers, then
// random greetings and CONNECT requests, some cut short or mangled, with
// stray bytes between sessions. Both channels stall at random in the first
// two of three pressure phases. Results are checked by shp_result_check.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_tb;

   logic       clock;
   logic       reset;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         bytes_sent;
   int         sessions_sent;
   int         fail_count;
   int         pending_count;
   int         checked_count;
   int         connect_count;
   logic [7:0] session_q[$];

   shp_req_if req_ch ();
   shp_rsp_if rsp_ch ();

   socks5_handshake_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   shp_result_check result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .connect_count (connect_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // entered and left at a falling edge; valid stays up for a following item
   task automatic send_byte(input logic [7:0] b, input logic fresh);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.rx_byte     <= b;
      req_ch.new_session <= fresh;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_session(input logic fresh);
      foreach (session_q[i]) send_byte(session_q[i], (i == 0) ? fresh : 1'b0);
      bytes_sent += session_q.size();
      sessions_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      // let a byte still inside the parser or the queue come through
      repeat (8) @(negedge clock);
   endtask

   task automatic append_byte(input logic [7:0] b);
      session_q.insert(session_q.size(), b);
   endtask

   // greeting plus CONNECT request, mostly well formed
   task automatic build_session();
      int         nmeth;
      int         dlen;
      int         roll;
      logic [7:0] atyp;
      session_q.delete();
      append_byte(shp_pkg::K_VER);
      nmeth = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0) nmeth = 0;
      append_byte(8'(nmeth));
      for (int i = 0; i < nmeth; i++) append_byte(8'($urandom_range(0, 255)));
      if (nmeth > 0 && $urandom_range(0, 9) != 0)
         session_q[2 + $urandom_range(0, nmeth - 1)] = shp_pkg::K_NOAUTH;
      append_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : shp_pkg::K_VER);
      append_byte(($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : shp_pkg::K_CONNECT);
      append_byte(8'($urandom_range(0, 255)));
      roll = $urandom_range(0, 15);
      if (roll < 5) atyp = shp_pkg::K_AT_V4;
      else if (roll < 10) atyp = shp_pkg::K_AT_DOM;
      else if (roll < 15) atyp = shp_pkg::K_AT_V6;
      else atyp = 8'($urandom_range(0, 255));
      append_byte(atyp);
      if (atyp == shp_pkg::K_AT_V4) begin
         repeat (4) append_byte(8'($urandom_range(0, 255)));
      end else if (atyp == shp_pkg::K_AT_V6) begin
         repeat (16) append_byte(8'($urandom_range(0, 255)));
      end else if (atyp == shp_pkg::K_AT_DOM) begin
         dlen = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
         append_byte(8'(dlen));
         repeat (dlen) append_byte(8'($urandom_range(0, 255)));
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         append_byte(8'h00);
         append_byte(8'h00);
      end else if (roll == 1) begin
         append_byte(8'hFF);
         append_byte(8'hFF);
      end else begin
         append_byte(8'($urandom_range(0, 255)));
         append_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int rand_start;
      int roll;
      int keep;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.rx_byte     <= 8'h00;
      req_ch.new_session <= 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 70;
      bytes_sent    = 0;
      sessions_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first byte after reset without new_session, then a byte after the end
      send_byte(8'h47, 1'b0);
      send_byte(shp_pkg::K_VER, 1'b0);
      send_byte(shp_pkg::ASCII_Z, 1'b1);
      send_byte(8'h40, 1'b1);
      bytes_sent += 4;
      session_q = '{shp_pkg::K_VER, 8'h00};
      send_session(1'b1);
      session_q = '{shp_pkg::K_VER, 8'h01, 8'hFF};
      send_session(1'b1);
      // bad version and bad command together: version wins
      session_q = '{shp_pkg::K_VER, 8'h01, shp_pkg::K_NOAUTH, 8'h04, 8'h02, 8'h00,
                    shp_pkg::K_AT_DOM};
      send_session(1'b1);
      // empty domain name, port goes straight out
      session_q = '{shp_pkg::K_VER, 8'h01, shp_pkg::K_NOAUTH, shp_pkg::K_VER,
                    shp_pkg::K_CONNECT, 8'h00, shp_pkg::K_AT_DOM, 8'h00, 8'hFF, 8'hFF};
      send_session(1'b1);
      drain_results();

      rand_start = bytes_sent;
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 14 : (p == 1) ? 70 : 0;
         recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 14 : 0;
         while (bytes_sent < rand_start + (p + 1) * 125) begin
            roll = $urandom_range(0, 9);
            if (roll < 9) begin
               build_session();
               if (roll >= 7) begin
                  keep = $urandom_range(1, session_q.size() - 1);
                  while (session_q.size() > keep) void'(session_q.pop_back());
               end
            end else begin
               session_q.delete();
               append_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h3F, 8'h5C))
                                                       : 8'($urandom_range(0, 255)));
            end
            send_session($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 2)) begin
                  send_byte(8'($urandom_range(0, 255)), 1'b0);
                  bytes_sent++;
               end
            end
         end
         drain_results();
      end

      $display("Fed %0d client bytes in %0d sessions: openers, greetings, CONNECT requests,",
               bytes_sent, sessions_sent);
      $display("cut-short and noisy streams; %0d items checked, %0d CONNECTs completed",
               checked_count, connect_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* socks5_handshake_parser.f */
design/shp_pkg.sv
design/shp_if.sv
design/shp_front.sv
design/shp_queue.sv
design/shp_back.sv
design/socks5_handshake_parser.sv
tb/shp_result_check.sv
tb/socks5_handshake_parser_tb.sv
